// File: hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the duration statistics table
// Field widths, operation codes, the table entry layout and divider status.
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int OP_W  = 2;
  localparam int ID_W  = 8;
  localparam int TICK_W = 32;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // one table row
  typedef struct packed {
    logic [TICK_W-1:0] start_stamp;
    logic [TICK_W-1:0] total_ticks;
    logic [TICK_W-1:0] done_count;
    logic [TICK_W-1:0] least_ticks;
    logic [TICK_W-1:0] most_ticks;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/dst_in_if.sv
// ----------------------------------------------------------------------------
// dst_in_if: request channel of the duration statistics table
// Carries one operation word: operation, metric number and timer value.
// ----------------------------------------------------------------------------
interface dst_in_if;
  import dst_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   metric_num;
  logic [TICK_W-1:0] now_ticks;

  modport source (output valid, output operation, output metric_num, output now_ticks,
                  input ready);
  modport sink   (input valid, input operation, input metric_num, input now_ticks,
                  output ready);
endinterface

// File: hw/rtl/dst_out_if.sv
// ----------------------------------------------------------------------------
// dst_out_if: result channel of the duration statistics table
// Carries one statistics word per request.
// ----------------------------------------------------------------------------
interface dst_out_if;
  import dst_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [TICK_W-1:0] mean_duration;
  logic [TICK_W-1:0] min_duration;
  logic [TICK_W-1:0] max_duration;
  logic [TICK_W-1:0] measure_count;

  modport source (output valid, output status, output mean_duration, output min_duration,
                  output max_duration, output measure_count, input ready);
  modport sink   (input valid, input status, input mean_duration, input min_duration,
                  input max_duration, input measure_count, output ready);
endinterface

// File: hw/rtl/dst_div.sv
// ----------------------------------------------------------------------------
// dst_div: radix-2 restoring unsigned divider
// One quotient bit per cycle; done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module dst_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dst_pkg::TICK_W-1:0] dividend,
  input  logic [dst_pkg::TICK_W-1:0] divisor,
  output logic [dst_pkg::TICK_W-1:0] quotient,
  output dst_pkg::div_stat_t         stat
);
  import dst_pkg::*;

  localparam int CNT_W = $clog2(TICK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TICK_W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TICK_W-1:0]   rem_r, rem_nxt;
  logic [TICK_W-1:0]   quo_r, quo_nxt;
  logic [TICK_W-1:0]   dsr_r, dsr_nxt;
  logic [TICK_W:0]     trial;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[TICK_W-1]} - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[TICK_W]) begin
        rem_nxt = trial[TICK_W-1:0];
        quo_nxt = {quo_r[TICK_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[TICK_W-2:0], quo_r[TICK_W-1]};
        quo_nxt = {quo_r[TICK_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: hw/rtl/duration_stats_table.sv
// ----------------------------------------------------------------------------
// duration_stats_table: per-metric start/end duration statistics
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready); each word names an operation
// (start, end, query), a metric number and the current timer value. Every
// request returns exactly one word on out_ch with status, mean, min, max and
// count of the metric as they stand after the request.
// One request is handled at a time; in_ch.ready is high only while idle.
// Each request passes through idle, the duration step (ST_DUR) on the
// registered table read, the row update (ST_UPD), the 32-step divider for
// the mean (ST_DIV) and the result push (ST_PUSH). The divider is skipped
// when the metric has no measurements, and an out-of-range metric goes from
// idle straight to the result push. The result waits in an output register;
// a new request can be taken while it waits, and a finished result stalls
// only until that register frees.
// Reset clears per-row valid bits, so all rows read as zero at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module duration_stats_table #(
  parameter int NUM_METRICS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dst_in_if.sink    in_ch,
  dst_out_if.source out_ch
);
  import dst_pkg::*;

  localparam int IDX_W = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
  localparam logic [ID_W:0] ID_LIMIT = (ID_W+1)'(NUM_METRICS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DUR  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // table memory plus reset-cleared row valid bits
  entry_t              mem [NUM_METRICS];
  logic [NUM_METRICS-1:0] row_vld_r;
  entry_t              rd_data_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_addr;

  // request latch
  logic [OP_W-1:0]     op_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TICK_W-1:0]   now_r;

  // working registers
  entry_t              ent_r, ent_nxt;
  logic [TICK_W-1:0]   dur_r;
  logic                bad_r, bad_nxt;
  logic [TICK_W-1:0]   mean_r, mean_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                o_status_r;
  logic [TICK_W-1:0]   o_mean_r, o_min_r, o_max_r, o_cnt_r;

  logic                in_take;
  logic                id_ok;
  logic                out_free;
  logic                mem_we;
  logic                div_start;
  logic [TICK_W-1:0]   div_quo;
  div_stat_t           div_stat;

  assign id_ok    = ({1'b0, in_ch.metric_num} < ID_LIMIT);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_addr  = in_ch.metric_num[IDX_W-1:0];

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);

  // read-modify of the latched row
  always_comb begin
    ent_nxt = ent_r;
    case (op_r)
      OP_START: ent_nxt.start_stamp = now_r;
      OP_END: begin
        ent_nxt.total_ticks = ent_r.total_ticks + dur_r;
        ent_nxt.done_count  = ent_r.done_count + 1'b1;
        if (ent_r.done_count == '0) begin
          // first measurement after reset or count wrap
          ent_nxt.least_ticks = dur_r;
          ent_nxt.most_ticks  = dur_r;
        end else begin
          if (dur_r < ent_r.least_ticks) ent_nxt.least_ticks = dur_r;
          if (dur_r > ent_r.most_ticks)  ent_nxt.most_ticks  = dur_r;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  assign mem_we    = (state_r == ST_UPD) && ((op_r == OP_START) || (op_r == OP_END));
  assign div_start = (state_r == ST_UPD) && (ent_nxt.done_count != '0);

  always_comb begin
    state_nxt     = state_r;
    bad_nxt       = bad_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          bad_nxt  = !id_ok;
          mean_nxt = '0;
          state_nxt = id_ok ? ST_DUR : ST_PUSH;
        end
      end
      ST_DUR: state_nxt = ST_UPD;
      ST_UPD: state_nxt = div_start ? ST_DIV : ST_PUSH;
      ST_DIV: begin
        if (div_stat.done) begin
          mean_nxt  = div_quo;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) row_vld_r[idx_r] <= 1'b1;
    end
  end

  // synchronous memory: one read, one write port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= row_vld_r[rd_addr];
    if (mem_we) mem[idx_r] <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    bad_r  <= bad_nxt;
    mean_r <= mean_nxt;
    if (in_take) begin
      op_r  <= in_ch.operation;
      idx_r <= rd_addr;
      now_r <= in_ch.now_ticks;
    end
    if (state_r == ST_DUR) begin
      ent_r <= rd_vld_r ? rd_data_r : '0;
      dur_r <= now_r - (rd_vld_r ? rd_data_r.start_stamp : '0);
    end
    if (state_r == ST_UPD) ent_r <= ent_nxt;
    if ((state_r == ST_PUSH) && out_free) begin
      o_status_r <= bad_r ? STATUS_BAD : STATUS_OK;
      o_mean_r   <= bad_r ? '0 : mean_r;
      o_min_r    <= bad_r ? '0 : ent_r.least_ticks;
      o_max_r    <= bad_r ? '0 : ent_r.most_ticks;
      o_cnt_r    <= bad_r ? '0 : ent_r.done_count;
    end
  end

  dst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ent_nxt.total_ticks),
    .divisor  (ent_nxt.done_count),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.mean_duration = o_mean_r;
  assign out_ch.min_duration  = o_min_r;
  assign out_ch.max_duration  = o_max_r;
  assign out_ch.measure_count = o_cnt_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_bad_id_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !id_ok) |=> (state_r == ST_PUSH))
    else $error("out-of-range metric did not go straight to result");

  a_push_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PUSH) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result not loaded into output register");

  a_upd_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> ((state_r == ST_DIV) || (state_r == ST_PUSH)))
    else $error("update step did not hand off to divide or result");

  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_stat.busy)
    else $error("divider busy while accepting a request");

endmodule

// File: verif/tb_duration_stats_table.sv
// ----------------------------------------------------------------------------
// tb_duration_stats_table: self-checking bench of the duration statistics table
// Drives start/end/query words with random gaps, predicts every statistics
// word from a local copy of the table and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_duration_stats_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dst_pkg::*;

  localparam int NUM_METRICS = 16;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // decodes as a query
  localparam int PHASE_ITEMS = 270;
  localparam int LONG_HOLD = 500;
  localparam int DRAIN_CYCLES = 60;
  localparam realtime TIMEOUT = 20ms;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   metric_num;
    logic [TICK_W-1:0] now_ticks;
  } timer_req_t;

  typedef struct packed {
    logic              status;
    logic [TICK_W-1:0] mean_duration;
    logic [TICK_W-1:0] min_duration;
    logic [TICK_W-1:0] max_duration;
    logic [TICK_W-1:0] measure_count;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dst_in_if  in_ch ();
  dst_out_if out_ch ();

  duration_stats_table #(.NUM_METRICS(NUM_METRICS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the table
  logic [TICK_W-1:0] stamp_tbl [NUM_METRICS];
  logic [TICK_W-1:0] total_tbl [NUM_METRICS];
  logic [TICK_W-1:0] count_tbl [NUM_METRICS];
  logic [TICK_W-1:0] least_tbl [NUM_METRICS];
  logic [TICK_W-1:0] most_tbl  [NUM_METRICS];

  timer_req_t req_pending[$];
  stats_t     stats_expected[$];
  timer_req_t req_on_bus;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic pressure_go = 1'b0;

  int mismatch_cnt = 0;
  int req_accepted = 0;
  int stats_seen = 0;
  int in_range_cnt = 0;
  int bad_id_cnt = 0;
  int held_cycles = 0;

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  initial begin : reset_gen
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.metric_num = '0;
    in_ch.now_ticks = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("FAILURE");
    $finish;
  end

  function automatic stats_t predict_stats(timer_req_t r);
    logic [TICK_W-1:0] dur;
    stats_t s;
    s = '0;
    if (r.metric_num >= NUM_METRICS) begin
      s.status = STATUS_BAD;
      return s;
    end
    if (r.operation == OP_START) begin
      stamp_tbl[r.metric_num] = r.now_ticks;
    end else if (r.operation == OP_END) begin
      dur = r.now_ticks - stamp_tbl[r.metric_num];
      total_tbl[r.metric_num] += dur;
      count_tbl[r.metric_num] += 1;
      // first measurement after reset or a count wrap seeds min and max
      if (count_tbl[r.metric_num] == 1) begin
        least_tbl[r.metric_num] = dur;
        most_tbl[r.metric_num] = dur;
      end else begin
        if (dur < least_tbl[r.metric_num]) least_tbl[r.metric_num] = dur;
        if (dur > most_tbl[r.metric_num]) most_tbl[r.metric_num] = dur;
      end
    end
    s.status = STATUS_OK;
    s.mean_duration = (count_tbl[r.metric_num] == 0) ? '0
                    : total_tbl[r.metric_num] / count_tbl[r.metric_num];
    s.min_duration = least_tbl[r.metric_num];
    s.max_duration = most_tbl[r.metric_num];
    s.measure_count = count_tbl[r.metric_num];
    return s;
  endfunction

  always @(posedge clk) begin : req_driver
    timer_req_t nxt;
    logic offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        stats_expected.push_back(predict_stats(req_on_bus));
        req_accepted++;
        offer = 1'b0;
      end
      if (in_ch.valid && !in_ch.ready && rx_hold) held_cycles++;
      if (!offer && req_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = req_pending.pop_front();
        in_ch.operation <= nxt.operation;
        in_ch.metric_num <= nxt.metric_num;
        in_ch.now_ticks <= nxt.now_ticks;
        req_on_bus = nxt;
        offer = 1'b1;
      end
      in_ch.valid <= offer;
    end
  end

  task automatic check_field(string name, logic [TICK_W-1:0] want, logic [TICK_W-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : stats_monitor
    stats_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      stats_seen++;
      if (stats_expected.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word: expected none, actual status %h count %h",
                 $time, out_ch.status, out_ch.measure_count);
      end else begin
        want = stats_expected.pop_front();
        check_field("status", TICK_W'(want.status), TICK_W'(out_ch.status));
        check_field("mean_duration", want.mean_duration, out_ch.mean_duration);
        check_field("min_duration", want.min_duration, out_ch.min_duration);
        check_field("max_duration", want.max_duration, out_ch.max_duration);
        check_field("measure_count", want.measure_count, out_ch.measure_count);
      end
    end
    out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long result stall; input keeps offering so the block backs up
  initial begin : rx_hold_gen
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic void push_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [TICK_W-1:0] now);
    timer_req_t r;
    r.operation = op;
    r.metric_num = id;
    r.now_ticks = now;
    req_pending.push_back(r);
    if (id < NUM_METRICS) in_range_cnt++;
    else bad_id_cnt++;
  endfunction

  task automatic wait_drained();
    while (req_pending.size() != 0 || in_ch.valid || stats_expected.size() != 0)
      @(negedge clk);
  endtask

  task automatic push_random(int target);
    int start_cnt;
    logic [ID_W-1:0] slot;
    logic [TICK_W-1:0] t0;
    logic [TICK_W-1:0] dur;
    int pick;
    start_cnt = in_range_cnt;
    while (in_range_cnt - start_cnt < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed start/end pair, often followed by a query
        slot = ID_W'($urandom_range(NUM_METRICS - 1));
        t0 = $urandom;
        pick = $urandom_range(99);
        if (pick < 50) dur = $urandom_range(1000);
        else if (pick < 60) dur = '0;
        else if (pick < 70) dur = '1 - $urandom_range(15);
        else dur = $urandom;
        push_req(OP_START, slot, t0);
        push_req(OP_END, slot, t0 + dur);
        if ($urandom_range(1)) push_req($urandom_range(1) ? OP_QUERY : OP_SPARE, slot, $urandom);
      end else begin
        // noise: any op, mostly valid slots, some out of range
        slot = ($urandom_range(3) == 0) ? ID_W'($urandom_range(255))
                                        : ID_W'($urandom_range(NUM_METRICS - 1));
        push_req(OP_W'($urandom_range(3)), slot, $urandom);
      end
    end
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int target);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    push_random(target);
    wait_drained();
  endtask

  initial begin : stimulus
    for (int i = 0; i < NUM_METRICS; i++) begin
      stamp_tbl[i] = '0;
      total_tbl[i] = '0;
      count_tbl[i] = '0;
      least_tbl[i] = '0;
      most_tbl[i] = '0;
    end
    wait (rst_n);
    @(negedge clk);

    // directed: empty slot, bad ids, end without start, timer and total wrap
    push_req(OP_QUERY, 8'd0, 32'h0000_0000);
    push_req(OP_SPARE, 8'd15, 32'hFFFF_FFFF);
    push_req(OP_START, 8'd16, 32'h1234_5678);
    push_req(OP_END, 8'd255, 32'hFFFF_FFFF);
    push_req(OP_QUERY, 8'd128, 32'h0000_0001);
    push_req(OP_SPARE, 8'd255, 32'h0000_0000);
    push_req(OP_END, 8'd1, 32'hFFFF_FFFF);
    push_req(OP_END, 8'd1, 32'h0000_0000);
    push_req(OP_END, 8'd1, 32'h0000_0005);
    push_req(OP_START, 8'd2, 32'hFFFF_FFF0);
    push_req(OP_END, 8'd2, 32'h0000_0010);
    push_req(OP_START, 8'd2, 32'h0000_0100);
    push_req(OP_END, 8'd2, 32'h0000_0100);
    push_req(OP_QUERY, 8'd2, 32'hDEAD_BEEF);
    push_req(OP_START, 8'd15, 32'hFFFF_FFFF);
    push_req(OP_END, 8'd15, 32'hFFFF_FFFE);
    push_req(OP_START, 8'd15, 32'h0000_0000);
    push_req(OP_END, 8'd15, 32'hFFFF_FFFF);
    push_req(OP_SPARE, 8'd15, 32'h5555_5555);
    push_req(OP_START, 8'd0, 32'hA5A5_A5A5);
    push_req(OP_END, 8'd0, 32'h5A5A_5A5A);
    push_req(OP_QUERY, 8'd0, 32'hAAAA_AAAA);
    push_req(OP_END, 8'd16, 32'hFFFF_FFFF);
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(77, 0, PHASE_ITEMS);
    run_phase(0, 77, PHASE_ITEMS);
    run_phase(17, 17, PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    pressure_go = 1'b1;
    push_random(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d request words (%0d valid slots, %0d bad ids), %0d result words checked,",
             req_accepted, in_range_cnt, bad_id_cnt, stats_seen);
    $display("over idle-free, sender-idle, receiver-stall, mixed and long-stall phases (%0d held).",
             held_cycles);
    if (mismatch_cnt == 0 && stats_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
